FILE: sv/lifegrid_pkg.sv
package lifegrid_pkg;

   localparam int GRID_SIZE_DEF = 16;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_STEP = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_LOAD = 4'b0010,
      S_READ = 4'b0100,
      S_STEP = 4'b1000
   } state_type;

endpackage

FILE: sv/life_automaton_grid_step.sv
// Conway life grid of GRID_SIZE x GRID_SIZE cells, one memory row per grid row. A load reads
// the row and writes it back with one bit changed, and gives no result. A read gives one
// item on rsp_alive; it waits in place while a finished result is still stalled. A step
// accepts the request and then sweeps: the sweep reads one row per cycle through the single
// read port and writes the new generation two rows behind, keeping the old rows above and
// in the middle in registers. req_stall is high until the current item is done. Rows carry
// a valid bit cleared by reset, so the grid starts dead without a clearing pass. Load and
// read outside the grid are ignored (a read then returns dead); opcode three is dropped.
module life_automaton_grid_step
   import lifegrid_pkg::*;
#(
   parameter int GRID_SIZE = GRID_SIZE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_opcode,
   input  logic [3:0] req_row,
   input  logic [3:0] req_col,
   input  logic       req_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_alive
);

   localparam int ROW_W = $clog2(GRID_SIZE);
   localparam int CNT_W = $clog2(GRID_SIZE + 2);

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [ROW_W-1:0]       row_ff, col_ff;
   logic                   value_ff, inside_ff;
   logic [GRID_SIZE-1:0]   grid_ff [GRID_SIZE];
   logic [GRID_SIZE-1:0]   row_vld_ff;
   logic [GRID_SIZE-1:0]   rdata_ff;
   logic                   rdata_vld_ff;
   logic [GRID_SIZE-1:0]   above_ff, mid_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_alive_ff, rsp_alive_in;

   logic                   req_inside;
   logic [ROW_W-1:0]       rd_addr, wr_addr;
   logic                   wr_en;
   logic [GRID_SIZE-1:0]   wr_data;
   logic [GRID_SIZE-1:0]   row_data, below, next_row;

   assign req_inside = (32'(req_row) < 32'(GRID_SIZE)) && (32'(req_col) < 32'(GRID_SIZE));
   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_alive  = rsp_alive_ff;

   // Rows never written read as dead
   assign row_data = rdata_vld_ff ? rdata_ff : '0;
   assign below    = (cnt_ff <= CNT_W'(GRID_SIZE)) ? row_data : '0;

   always_comb begin
      case (state_ff)
         S_IDLE:  rd_addr = ROW_W'(req_row);
         S_STEP:  rd_addr = cnt_ff[ROW_W-1:0];
         default: rd_addr = row_ff;
      endcase
   end

   always_comb begin
      logic [GRID_SIZE+1:0] a_x, m_x, b_x;
      logic [3:0]           n;
      a_x = {1'b0, above_ff, 1'b0};
      m_x = {1'b0, mid_ff, 1'b0};
      b_x = {1'b0, below, 1'b0};
      next_row = '0;
      for (int c = 0; c < GRID_SIZE; c++) begin
         n = 4'(a_x[c]) + 4'(a_x[c+1]) + 4'(a_x[c+2])
           + 4'(m_x[c]) + 4'(m_x[c+2])
           + 4'(b_x[c]) + 4'(b_x[c+1]) + 4'(b_x[c+2]);
         next_row[c] = (n == 4'd3) || (mid_ff[c] && (n == 4'd2));
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = row_ff;
      wr_data = row_data;
      case (state_ff)
         S_LOAD: begin
            wr_en            = 1'b1;
            wr_data[col_ff]  = value_ff;
         end
         S_STEP: begin
            wr_en   = (cnt_ff >= CNT_W'(2));
            wr_addr = ROW_W'(cnt_ff - CNT_W'(2));
            wr_data = next_row;
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_alive_in = rsp_alive_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_opcode)
                  OP_LOAD: if (req_inside) state_in = S_LOAD;
                  OP_STEP: begin
                     state_in = S_STEP;
                     cnt_in   = '0;
                  end
                  OP_READ: state_in = S_READ;
                  default: ;
               endcase
            end
         end
         S_LOAD: state_in = S_IDLE;
         S_READ: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_alive_in = inside_ff && row_data[col_ff];
               state_in     = S_IDLE;
            end
         end
         S_STEP: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(GRID_SIZE + 1)) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         row_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) row_vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rsp_alive_ff <= rsp_alive_in;
      if (state_ff == S_IDLE && req_valid) begin
         row_ff    <= ROW_W'(req_row);
         col_ff    <= ROW_W'(req_col);
         value_ff  <= req_value;
         inside_ff <= req_inside;
      end
      // shift the old rows down the sweep window
      if (state_ff == S_STEP) begin
         if (cnt_ff == '0) begin
            above_ff <= '0;
            mid_ff   <= '0;
         end else begin
            above_ff <= mid_ff;
            mid_ff   <= below;
         end
      end
   end

   // Row memory: one read and one write port, registered read data
   always_ff @(posedge clock) begin
      if (wr_en) grid_ff[wr_addr] <= wr_data;
      rdata_ff     <= grid_ff[rd_addr];
      rdata_vld_ff <= row_vld_ff[rd_addr];
   end

`ifndef SYNTH
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_READ))
      else $error("result raised outside a read");

   a_step_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP && wr_en && cnt_ff < CNT_W'(GRID_SIZE)) |-> (wr_addr != rd_addr))
      else $error("step writes the row being read");

   a_step_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP && cnt_ff == CNT_W'(GRID_SIZE + 1)) |=> (state_ff == S_IDLE))
      else $error("step sweep did not finish");

   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |=> (state_ff == S_IDLE && row_vld_ff[$past(row_ff)]))
      else $error("load write-back missing");
`endif

endmodule

FILE: test/life_automaton_grid_step_chk.sv
module life_automaton_grid_step_chk
   import lifegrid_pkg::*;
#(
   parameter int GS = GRID_SIZE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [1:0] req_opcode,
   input  logic [3:0] req_row,
   input  logic [3:0] req_col,
   input  logic       req_value,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_alive,
   output int         mismatches,
   output int         outstanding,
   output int         reads_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [GS-1:0] board [GS];
   logic          expected_alive [$];
   int            fail_count;
   int            checked_count;

   // Judge every cell on the old generation only; cells off the edge are dead.
   task automatic advance_generation();
      logic [GS-1:0] prev [GS];
      int            n;
      int            rr;
      int            cc;
      for (int r = 0; r < GS; r++) prev[r] = board[r];
      for (int r = 0; r < GS; r++) begin
         for (int c = 0; c < GS; c++) begin
            n = 0;
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  rr = r + dr;
                  cc = c + dc;
                  if ((dr != 0 || dc != 0) && rr >= 0 && rr < GS && cc >= 0 && cc < GS)
                     n += prev[rr][cc];
               end
            end
            board[r][c] = (n == 3) || (prev[r][c] && n == 2);
         end
      end
   endtask

   always @(posedge clock) begin : watch
      logic want;
      logic in_grid;
      if (reset) begin
         for (int r = 0; r < GS; r++) board[r] = '0;
         expected_alive.delete();
         fail_count    = 0;
         checked_count = 0;
      end else begin
         // Retire the oldest expectation before queuing a new one.
         if (rsp_valid && !rsp_stall) begin
            if (expected_alive.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: result alive=%0b with no read waiting", $realtime, rsp_alive);
            end else begin
               want = expected_alive.pop_front();
               checked_count++;
               if (rsp_alive !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: alive expected %0b, got %0b", $realtime, want, rsp_alive);
               end
            end
         end
         if (req_valid && !req_stall) begin
            in_grid = (req_row < GS) && (req_col < GS);
            case (req_opcode)
               OP_LOAD: begin
                  if (in_grid) board[req_row][req_col] = req_value;
               end
               OP_STEP: begin
                  advance_generation();
               end
               OP_READ: begin
                  expected_alive.push_back(in_grid ? board[req_row][req_col] : 1'b0);
               end
               default: begin
                  // opcode three: drop
               end
            endcase
         end
      end
      mismatches    <= fail_count;
      outstanding   <= expected_alive.size();
      reads_checked <= checked_count;
   end

endmodule

FILE: test/life_automaton_grid_step_tb.sv
module life_automaton_grid_step_tb;
   import lifegrid_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_NONE        = 2'd3;
   localparam int         ITEM_TARGET    = 1250;
   localparam int         HOLDOFF_CYCLES = 300;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         TAIL_CYCLES    = 40;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_valid  = 1'b0;
   logic [1:0] req_opcode = OP_LOAD;
   logic [3:0] req_row    = '0;
   logic [3:0] req_col    = '0;
   logic       req_value  = 1'b0;
   logic       rsp_stall  = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic       rsp_alive;

   int mismatches;
   int outstanding;
   int reads_checked;
   int items_sent;
   int n_load;
   int n_step;
   int n_read;
   int n_drop;
   int quiet_cycles;
   bit sender_idles    = 1'b1;
   bit receiver_stalls = 1'b1;
   bit holdoff_req     = 1'b0;
   bit holdoff_done    = 1'b0;

   life_automaton_grid_step i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .req_row    (req_row),
      .req_col    (req_col),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_alive  (rsp_alive)
   );

   life_automaton_grid_step_chk i_chk (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_alive     (rsp_alive),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .reads_checked (reads_checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic send_item(input logic [1:0] op, input logic [3:0] r, input logic [3:0] c,
                            input logic v);
      int gap;
      gap = sender_idles ? $urandom_range(0, 5) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_row    <= r;
      req_col    <= c;
      req_value  <= v;
      case (op)
         OP_LOAD: n_load++;
         OP_STEP: n_step++;
         OP_READ: n_read++;
         default: n_drop++;
      endcase
      if (op != OP_NONE) items_sent++;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // Stop offering items, then wait until every read has been answered.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic logic rand_alive();
      return $urandom_range(0, 9) < 6;
   endfunction

   // Load a cluster of cells, evolve it, then read back around it.
   task automatic cluster_sequence();
      int base_r;
      int base_c;
      int h;
      int w;
      base_r = $urandom_range(0, 15);
      base_c = $urandom_range(0, 15);
      h      = $urandom_range(2, 6);
      w      = $urandom_range(2, 6);
      repeat ($urandom_range(3, 16))
         send_item(OP_LOAD, 4'(base_r + $urandom_range(0, h - 1)),
                   4'(base_c + $urandom_range(0, w - 1)), rand_alive());
      repeat ($urandom_range(1, 3)) send_item(OP_STEP, 4'($urandom), 4'($urandom), 1'($urandom));
      repeat ($urandom_range(2, 8))
         send_item(OP_READ, 4'(base_r + $urandom_range(0, h) - 1),
                   4'(base_c + $urandom_range(0, w) - 1), 1'($urandom));
   endtask

   task automatic noise_sequence();
      repeat ($urandom_range(2, 6))
         send_item(2'($urandom), 4'($urandom), 4'($urandom), 1'($urandom));
   endtask

   initial begin : receiver
      int n;
      @(negedge clock);
      forever begin
         n = receiver_stalls ? $urandom_range(0, 5) : 0;
         if (holdoff_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLDOFF_CYCLES + n) @(negedge clock);
            holdoff_req = 1'b0;
         end else if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall) && !holdoff_req);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d reads pending",
                  quiet_cycles, outstanding);
         $display("life_automaton_grid_step_tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Corners, an L of three cells that grows into a block, and a blinker.
      send_item(OP_READ, 4'd0, 4'd0, 1'b0);
      send_item(OP_READ, 4'd15, 4'd15, 1'b1);
      send_item(OP_LOAD, 4'd0, 4'd0, 1'b1);
      send_item(OP_LOAD, 4'd0, 4'd1, 1'b1);
      send_item(OP_LOAD, 4'd1, 4'd0, 1'b1);
      send_item(OP_LOAD, 4'd15, 4'd15, 1'b1);
      send_item(OP_LOAD, 4'd15, 4'd14, 1'b1);
      send_item(OP_LOAD, 4'd14, 4'd15, 1'b1);
      send_item(OP_STEP, 4'd0, 4'd0, 1'b0);
      send_item(OP_READ, 4'd1, 4'd1, 1'b0);
      send_item(OP_READ, 4'd14, 4'd14, 1'b0);
      send_item(OP_NONE, 4'd15, 4'd15, 1'b1);
      send_item(OP_LOAD, 4'd0, 4'd0, 1'b0);
      send_item(OP_READ, 4'd0, 4'd0, 1'b0);
      send_item(OP_LOAD, 4'd7, 4'd6, 1'b1);
      send_item(OP_LOAD, 4'd7, 4'd7, 1'b1);
      send_item(OP_LOAD, 4'd7, 4'd8, 1'b1);
      send_item(OP_STEP, 4'd15, 4'd15, 1'b1);
      send_item(OP_READ, 4'd6, 4'd7, 1'b0);
      send_item(OP_READ, 4'd8, 4'd7, 1'b0);
      send_item(OP_READ, 4'd7, 4'd6, 1'b0);
      send_item(OP_STEP, 4'd0, 4'd0, 1'b0);
      send_item(OP_READ, 4'd7, 4'd8, 1'b0);
      send_item(OP_READ, 4'd0, 4'd1, 1'b0);

      while (items_sent < ITEM_TARGET) begin
         sender_idles    = $urandom_range(0, 3) != 0;
         receiver_stalls = $urandom_range(0, 3) != 0;
         if ($urandom_range(0, 9) == 0) noise_sequence();
         else cluster_sequence();
         if ($urandom_range(0, 7) == 0) drain();
         if (!holdoff_done && items_sent > ITEM_TARGET / 2) begin
            // Park the receiver and keep reading until the block backs up.
            holdoff_req = 1'b1;
            repeat (24) send_item(OP_READ, 4'($urandom), 4'($urandom), 1'($urandom));
            holdoff_done = 1'b1;
            drain();
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("life_automaton_grid_step_tb: %0d loads, %0d steps, %0d reads, %0d dropped",
               n_load, n_step, n_read, n_drop);
      $display("life_automaton_grid_step_tb: %0d cell reads compared, %0d mismatches",
               reads_checked, mismatches);
      if (mismatches == 0 && outstanding == 0) begin
         $display("life_automaton_grid_step_tb: done, clean");
      end else begin
         $display("life_automaton_grid_step_tb: done, errors");
      end
      $finish;
   end

endmodule
